// File: design/gf2i_pkg.sv
// ----------------------------------------------------------------------------
// gf2i_pkg: shared types for the GF(2^m) extended Euclid inverter
// Controller states, datapath operations and status, and the modulus that
// the configuration register holds after reset.
// ----------------------------------------------------------------------------
package gf2i_pkg;

    // Modulus after reset: x^10 + x^3 + 1, truncated to the register width
    localparam logic [31:0] RESET_MODULUS = 32'd1033;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LOAD,
        DP_NORM_SHIFT,
        DP_DIV_SHIFT,
        DP_DIV_SWAP
    } t_dp_op;

    typedef struct packed {
        logic rb_zero;
        logic rb_top;
    } t_dp_status;

endpackage

// File: design/gf2i_datapath.sv
// ----------------------------------------------------------------------------
// gf2i_datapath: remainder and cofactor shift registers
// Holds r_prev and r_curr left-aligned so the leading term sits in the top
// bit, and the cofactors w_prev and w_curr (the latter pre-shifted by the
// current quotient position). One quotient bit is resolved per cycle.
// ----------------------------------------------------------------------------
module gf2i_datapath #(
    parameter int DEGREE = 10
) (
    input  logic                  i_clk,
    input  gf2i_pkg::t_dp_op      i_op,
    input  logic [DEGREE-1:0]     i_modulus,
    input  logic [DEGREE-1:0]     i_operand,
    output gf2i_pkg::t_dp_status  o_status,
    output logic [DEGREE-1:0]     o_wa
);

    localparam int W = DEGREE + 1;

    logic [W-1:0] r_ra, r_rb, r_wa, r_wb;
    logic [W-1:0] n_ra, n_rb, n_wa, n_wb;
    logic [W-1:0] w_ra_sub, w_wa_sub;

    // Subtract the aligned divisor when the leading term of r_prev is set
    always_comb begin
        w_ra_sub = r_ra[W-1] ? (r_ra ^ r_rb) : r_ra;
        w_wa_sub = r_ra[W-1] ? (r_wa ^ r_wb) : r_wa;
    end

    always_comb begin
        n_ra = r_ra;
        n_rb = r_rb;
        n_wa = r_wa;
        n_wb = r_wb;
        unique case (i_op)
            gf2i_pkg::DP_LOAD: begin
                n_ra = {1'b1, i_modulus};
                n_rb = {1'b0, i_operand};
                n_wa = '0;
                n_wb = {{(W-1){1'b0}}, 1'b1};
            end
            gf2i_pkg::DP_NORM_SHIFT: begin
                // normalise r_curr; its cofactor moves with the quotient position
                n_rb = {r_rb[W-2:0], 1'b0};
                n_wb = {r_wb[W-2:0], 1'b0};
            end
            gf2i_pkg::DP_DIV_SHIFT: begin
                n_ra = {w_ra_sub[W-2:0], 1'b0};
                n_wa = w_wa_sub;
                n_wb = {1'b0, r_wb[W-1:1]};
            end
            gf2i_pkg::DP_DIV_SWAP: begin
                // last quotient bit: remainder becomes the new r_curr
                n_ra = r_rb;
                n_wa = r_wb;
                n_rb = w_ra_sub;
                n_wb = w_wa_sub;
            end
            gf2i_pkg::DP_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ra <= n_ra;
        r_rb <= n_rb;
        r_wa <= n_wa;
        r_wb <= n_wb;
    end

    assign o_status.rb_zero = (r_rb == '0);
    assign o_status.rb_top  = r_rb[W-1];
    assign o_wa             = r_wa[DEGREE-1:0];

endmodule

// File: design/gf2i_ctrl.sv
// ----------------------------------------------------------------------------
// gf2i_ctrl: sequencer for the inverter
// Steps the datapath through normalise and divide phases, tracking the
// degrees of r_prev and r_curr in two down counters.
// ----------------------------------------------------------------------------
module gf2i_ctrl #(
    parameter int DEGREE = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  gf2i_pkg::t_dp_status  i_status,
    input  logic                  i_out_free,
    output gf2i_pkg::t_dp_op      o_op,
    output logic                  o_finish,
    output logic                  o_gcd_one
);

    localparam int DW = $clog2(DEGREE + 1);

    gf2i_pkg::t_state r_state, n_state;
    logic [DW-1:0]    r_da, r_db, n_da, n_db;
    logic             w_deg_eq;

    assign w_deg_eq = (r_da == r_db);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gf2i_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = gf2i_pkg::ST_NORM;
                end
            end
            gf2i_pkg::ST_NORM: begin
                priority if (i_status.rb_zero) begin
                    n_state = gf2i_pkg::ST_DONE;
                end else if (i_status.rb_top) begin
                    n_state = gf2i_pkg::ST_DIV;
                end
            end
            gf2i_pkg::ST_DIV: begin
                if (w_deg_eq) begin
                    n_state = gf2i_pkg::ST_NORM;
                end
            end
            gf2i_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = gf2i_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gf2i_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_op       = gf2i_pkg::DP_HOLD;
        o_in_stall = 1'b1;
        o_finish   = 1'b0;
        unique case (r_state)
            gf2i_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_op = gf2i_pkg::DP_LOAD;
                end
            end
            gf2i_pkg::ST_NORM: begin
                if (!i_status.rb_zero && !i_status.rb_top) begin
                    o_op = gf2i_pkg::DP_NORM_SHIFT;
                end
            end
            gf2i_pkg::ST_DIV: begin
                o_op = w_deg_eq ? gf2i_pkg::DP_DIV_SWAP : gf2i_pkg::DP_DIV_SHIFT;
            end
            gf2i_pkg::ST_DONE: begin
                o_finish = i_out_free;
            end
            default: begin
            end
        endcase
    end

    // Degree counters follow the datapath operation
    always_comb begin
        n_da = r_da;
        n_db = r_db;
        unique case (o_op)
            gf2i_pkg::DP_LOAD: begin
                n_da = DW'(DEGREE);
                n_db = DW'(DEGREE);
            end
            gf2i_pkg::DP_NORM_SHIFT: begin
                n_db = r_db - 1'b1;
            end
            gf2i_pkg::DP_DIV_SHIFT: begin
                n_da = r_da - 1'b1;
            end
            gf2i_pkg::DP_DIV_SWAP: begin
                n_da = r_db;
            end
            gf2i_pkg::DP_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gf2i_pkg::ST_IDLE;
            r_da    <= '0;
            r_db    <= '0;
        end else begin
            r_state <= n_state;
            r_da    <= n_da;
            r_db    <= n_db;
        end
    end

    // Leading term of the final r_prev at x^0 means the gcd is 1
    assign o_gcd_one = (r_da == '0);

endmodule

// File: design/gf2m_inverse_ext_euclid.sv
// ----------------------------------------------------------------------------
// gf2m_inverse_ext_euclid: GF(2^DEGREE) inverse by extended Euclid
// Inverts a binary polynomial modulo the configured modulus polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_operand): one operand per item.
//   Output channel (o_out_valid / i_out_stall / o_inverse, o_inverse_exists):
//   one result item per operand, in order. o_inverse_exists is set when the
//   gcd with the modulus is 1; otherwise the inverse reads zero.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the
//   modulus; bit DEGREE is always taken as set. Write only while idle.
// Timing:
//   One item at a time. Remainders and cofactors move one bit per cycle, so
//   the time from acceptance to the output register grows with the number
//   of shifts; a zero operand is the quickest case.
//   The next item is accepted as soon as the result sits in the output
//   register, even while the receiver stalls it.
// Reset:
//   Synchronous, active low. Clears control state and loads the modulus
//   x^10 + x^3 + 1. A stalled result holds until taken; the block then waits
//   in its final state with its next result.
// ----------------------------------------------------------------------------
module gf2m_inverse_ext_euclid #(
    parameter int DEGREE = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [DEGREE-1:0] i_operand,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DEGREE-1:0] o_inverse,
    output logic              o_inverse_exists,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [DEGREE:0]   i_cfg_data
);

    logic [DEGREE-1:0]    r_modulus;
    logic                 r_out_valid;
    logic [DEGREE-1:0]    r_inverse;
    logic                 r_exists;

    gf2i_pkg::t_dp_op     w_op;
    gf2i_pkg::t_dp_status w_status;
    logic [DEGREE-1:0]    w_wa;
    logic                 w_finish;
    logic                 w_gcd_one;
    logic                 w_out_free;

    assign o_cfg_ready = 1'b1;

    // Only the low DEGREE bits are kept; the top coefficient is implied
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= DEGREE'(gf2i_pkg::RESET_MODULUS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_modulus <= i_cfg_data[DEGREE-1:0];
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    gf2i_ctrl #(
        .DEGREE (DEGREE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .i_out_free (w_out_free),
        .o_op       (w_op),
        .o_finish   (w_finish),
        .o_gcd_one  (w_gcd_one)
    );

    gf2i_datapath #(
        .DEGREE (DEGREE)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_op      (w_op),
        .i_modulus (r_modulus),
        .i_operand (i_operand),
        .o_status  (w_status),
        .o_wa      (w_wa)
    );

    // Output register: load on finish, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_inverse <= w_gcd_one ? w_wa : '0;
            r_exists  <= w_gcd_one;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_inverse        = r_inverse;
    assign o_inverse_exists = r_exists;

    // A result never overwrites one that is still waiting
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a stalled item");

    // An accepted item keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting an item");

    // No inverse without the flag
    a_zero_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_inverse_exists) |-> (o_inverse == '0))
        else $error("nonzero inverse with flag clear");

endmodule

// File: test/gf2m_inverse_ext_euclid_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf2m_inverse_ext_euclid_test: self-checking bench for the GF(2^m) inverter
// Drives operands under a range of modulus settings (reset value, extremes,
// reducible and random moduli) with random gaps and output stalls, predicts
// each inverse and its flag by polynomial Euclid, and checks every result in
// order against the prediction.
// ----------------------------------------------------------------------------
module gf2m_inverse_ext_euclid_test;

    localparam int DEGREE  = 10;
    // Worst-case time from acceptance to the output register, plus margin
    localparam int LATENCY = 4 * DEGREE + 8;
    localparam int PHASE_ITEMS = 200;

    typedef struct {
        logic [DEGREE-1:0] inverse;
        logic              exists;
    } t_inv_result;

    class inverse_ledger;
        logic [DEGREE:0] modulus;
        t_inv_result     awaited[$];
        int              failures;

        function new();
            modulus  = gf2i_pkg::RESET_MODULUS[DEGREE:0];
            failures = 0;
        endfunction

        function int poly_len(logic [DEGREE:0] x);
            for (int i = DEGREE; i >= 0; i--) begin
                if (x[i]) return i + 1;
            end
            return 0;
        endfunction

        // Extended Euclid over GF(2); the top bit of the modulus is forced set
        function t_inv_result gf_inverse(logic [DEGREE-1:0] a);
            logic [DEGREE:0]     r_prev, r_curr, rem, quo;
            logic [2*DEGREE+1:0] w_prev, w_curr, w_next;
            int                  ln, ld, sh;
            t_inv_result         res;
            r_prev = {1'b1, modulus[DEGREE-1:0]};
            r_curr = {1'b0, a};
            w_prev = '0;
            w_curr = (2*DEGREE+2)'(1);
            while (r_curr != 0) begin
                rem = r_prev;
                quo = '0;
                ld  = poly_len(r_curr);
                ln  = poly_len(rem);
                while (ln >= ld) begin
                    sh      = ln - ld;
                    quo[sh] = 1'b1;
                    rem     = rem ^ (r_curr << sh);
                    ln      = poly_len(rem);
                end
                w_next = w_prev;
                for (int i = 0; i <= DEGREE; i++) begin
                    if (quo[i]) w_next = w_next ^ (w_curr << i);
                end
                r_prev = r_curr;
                r_curr = rem;
                w_prev = w_curr;
                w_curr = w_next;
            end
            if (r_prev == 1) begin
                res.inverse = w_prev[DEGREE-1:0];
                res.exists  = 1'b1;
            end else begin
                res.inverse = '0;
                res.exists  = 1'b0;
            end
            return res;
        endfunction

        function void note_operand(logic [DEGREE-1:0] a);
            awaited.push_back(gf_inverse(a));
        endfunction

        function void check_result(logic [DEGREE-1:0] inverse, logic exists);
            t_inv_result want;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result %h/%b with nothing awaited", $realtime,
                             inverse, exists);
                return;
            end
            want = awaited.pop_front();
            if (inverse !== want.inverse || exists !== want.exists) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: inverse %h exists %b, expected %h exists %b",
                             $realtime, inverse, exists, want.inverse, want.exists);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [DEGREE-1:0] i_operand = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [DEGREE-1:0] o_inverse;
    logic              o_inverse_exists;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [DEGREE:0]   i_cfg_data = '0;

    inverse_ledger ledger = new();
    bit            idling = 1'b1;
    int            stall_left = 0;

    gf2m_inverse_ext_euclid #(
        .DEGREE (DEGREE)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operand        (i_operand),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_inverse        (o_inverse),
        .o_inverse_exists (o_inverse_exists),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) ledger.modulus = i_cfg_data;
            if (i_in_valid && !o_in_stall) ledger.note_operand(i_operand);
            if (o_out_valid && !i_out_stall) ledger.check_result(o_inverse, o_inverse_exists);
        end
    end

    // Receiver: stall in short random bursts while idling is allowed
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [DEGREE-1:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return DEGREE'(1);
                    default: return '1;
                endcase
            end
            1: return DEGREE'(1 << $urandom_range(0, DEGREE - 1));
            2: return DEGREE'($urandom & $urandom);
            default: return DEGREE'($urandom);
        endcase
    endfunction

    task automatic send_operand(input logic [DEGREE-1:0] a);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operand  <= a;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Hold off until every result is back and the block has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.awaited.size() != 0);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_modulus(input logic [DEGREE:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [DEGREE-1:0] corner_ops[12];
        logic [DEGREE:0]   moduli[9];
        corner_ops = '{10'h000, 10'h001, 10'h002, 10'h003, 10'h3FF, 10'h200,
                       10'h155, 10'h2AA, 10'h008, 10'h009, 10'h201, 10'h3FE};
        // Extremes, a cleared top bit, reducible moduli and random ones
        moduli = '{11'h7FF, 11'h000, 11'h409, 11'h3FF, 11'h400,
                   11'($urandom), 11'($urandom), 11'($urandom), 11'h409};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_ops[k]) send_operand(corner_ops[k]);
        repeat (PHASE_ITEMS) send_operand(pick_operand());

        foreach (moduli[p]) begin
            // Run one middle phase and the last one without any idling
            idling = (p != 3) && (p != 8);
            write_modulus(moduli[p]);
            repeat (PHASE_ITEMS) send_operand(pick_operand());
        end

        drain();
        if (ledger.failures == 0 && ledger.awaited.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
